[sv/opbd_pkg.sv]
package opbd_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int ROW_AW     = $clog2(MAX_HEIGHT);
    localparam int COL_AW     = $clog2(MAX_WIDTH);

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_NEXT  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BOUNDS  = 2'd1;
    localparam logic [1:0] STATUS_DIR     = 2'd2;
    localparam logic [1:0] STATUS_IGNORED = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAW,
        S_FINISH
    } state_t;

endpackage

[sv/opbd_ram.sv]
module opbd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/octilinear_polyline_bitmap_draw.sv]
// Octilinear polyline plotter over a 64 by 64 one-bit bitmap.
// The input channel (in_valid, in_ready, op, x, y) carries one transaction per
// command: start a polyline, add a point, read a row, or clear everything.
// The output channel (out_valid, out_ready, status, error_line, error_point,
// row_bits) returns exactly one transaction per command, in order.
// The configuration port (cfg_we, cfg_index, cfg_data) sets the active width
// and height; write it only while no command is in flight.
// Start, read and clear commands, and a point that fails its checks or is
// ignored, go from idle straight to the finish state, which loads the output
// register once it is free. A next-point command first passes through the
// draw state, which visits every bitmap row the segment touches (1 for a
// horizontal segment, up to 64 otherwise): the bitmap RAM does one row
// read-modify-write per cycle, with the read of one row overlapped with the
// write-back of the previous.
// The block takes a new command while a finished result still waits in the
// output register; if the receiver stalls, the following command completes
// its work and then holds until the output register frees up.
// Reset (rst_n, asynchronous, active low) and the clear command empty the
// bitmap at once through per-row valid bits; the RAM contents are never swept.
module octilinear_polyline_bitmap_draw (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [6:0]  x,
    input  logic [6:0]  y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] error_line,
    output logic [15:0] error_point,
    output logic [63:0] row_bits,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int W  = opbd_pkg::MAX_WIDTH;
    localparam int H  = opbd_pkg::MAX_HEIGHT;
    localparam int RA = opbd_pkg::ROW_AW;
    localparam int CA = opbd_pkg::COL_AW;

    // Control state.
    opbd_pkg::state_t state_reg, state_next;
    logic [6:0]  width_reg, width_next;
    logic [6:0]  height_reg, height_next;
    logic [H-1:0] row_valid_reg, row_valid_next;
    logic [CA-1:0] cursor_x_reg, cursor_x_next;
    logic [RA-1:0] cursor_y_reg, cursor_y_next;
    logic [15:0] line_count_reg, line_count_next;
    logic [15:0] point_count_reg, point_count_next;
    logic        error_seen_reg, error_seen_next;
    logic [15:0] err_line_reg, err_line_next;
    logic [15:0] err_point_reg, err_point_next;
    logic        out_valid_reg, out_valid_next;

    // Walker and write-back pipeline for segment drawing.
    logic [CA-1:0] draw_x_reg, draw_x_next;
    logic [RA-1:0] draw_y_reg, draw_y_next;
    logic [RA:0]   draw_left_reg, draw_left_next;
    logic          x_inc_reg, x_inc_next, x_dec_reg, x_dec_next;
    logic          y_inc_reg, y_inc_next, y_dec_reg, y_dec_next;
    logic          horiz_reg, horiz_next;
    logic [W-1:0]  hmask_reg, hmask_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [RA-1:0] pend_row_reg, pend_row_next;
    logic [W-1:0]  pend_mask_reg, pend_mask_next;
    logic          pend_live_reg, pend_live_next;

    // Item result held until the output register is free.
    logic [1:0]  op_reg, op_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic        rd_live_reg, rd_live_next;

    // Output payload registers.
    logic [1:0]  status_reg, status_next;
    logic [15:0] out_line_reg, out_line_next;
    logic [15:0] out_point_reg, out_point_next;
    logic [63:0] row_bits_reg, row_bits_next;

    // RAM port.
    logic          ram_we, ram_re;
    logic [RA-1:0] ram_waddr, ram_raddr;
    logic [W-1:0]  ram_wdata, ram_rdata;

    logic accept;
    logic out_free;

    // Geometry of a candidate segment from the cursor to (x, y).
    logic          pt_in, cur_in;
    logic [CA-1:0] px;
    logic [RA-1:0] py;
    logic signed [CA:0] dx, dy;
    logic [CA:0]   ax, ay;
    logic          bad_dir;
    logic [CA-1:0] lo_col, hi_col;
    logic [W-1:0]  range_mask;

    assign accept   = in_valid && (state_reg == opbd_pkg::S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready    = (state_reg == opbd_pkg::S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign error_line  = out_line_reg;
    assign error_point = out_point_reg;
    assign row_bits    = row_bits_reg;

    assign pt_in  = (x < width_reg) && (x < 7'(W)) && (y < height_reg) && (y < 7'(H));
    assign cur_in = ({1'b0, cursor_x_reg} < width_reg) && ({1'b0, cursor_y_reg} < height_reg);

    assign px = x[CA-1:0];
    assign py = y[RA-1:0];
    assign dx = $signed({1'b0, px}) - $signed({1'b0, cursor_x_reg});
    assign dy = $signed({1'b0, py}) - $signed({1'b0, cursor_y_reg});
    assign ax = dx[CA] ? (CA+1)'(-dx) : (CA+1)'(dx);
    assign ay = dy[CA] ? (CA+1)'(-dy) : (CA+1)'(dy);
    assign bad_dir = (dx != '0) && (dy != '0) && (ax != ay);

    // Columns lo..hi inclusive, used when the segment stays on one row.
    assign lo_col = (px < cursor_x_reg) ? px : cursor_x_reg;
    assign hi_col = (px < cursor_x_reg) ? cursor_x_reg : px;
    assign range_mask = ({W{1'b1}} << lo_col) & ({W{1'b1}} >> (CA'(W - 1) - hi_col));

    opbd_ram #(
        .WIDTH (W),
        .DEPTH (H)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            opbd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (in_valid && op == opbd_pkg::OP_NEXT && !error_seen_reg
                        && pt_in && cur_in && !bad_dir)
                    begin
                        state_next = opbd_pkg::S_DRAW;
                    end
                    else
                    begin
                        state_next = opbd_pkg::S_FINISH;
                    end
                end
            end
            opbd_pkg::S_DRAW:
            begin
                if (draw_left_reg == '0)
                begin
                    state_next = opbd_pkg::S_FINISH;
                end
            end
            opbd_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = opbd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = opbd_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, bookkeeping and RAM control.
    always_comb
    begin
        width_next       = width_reg;
        height_next      = height_reg;
        row_valid_next   = row_valid_reg;
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        line_count_next  = line_count_reg;
        point_count_next = point_count_reg;
        error_seen_next  = error_seen_reg;
        err_line_next    = err_line_reg;
        err_point_next   = err_point_reg;
        out_valid_next   = out_valid_reg;
        draw_x_next      = draw_x_reg;
        draw_y_next      = draw_y_reg;
        draw_left_next   = draw_left_reg;
        x_inc_next       = x_inc_reg;
        x_dec_next       = x_dec_reg;
        y_inc_next       = y_inc_reg;
        y_dec_next       = y_dec_reg;
        horiz_next       = horiz_reg;
        hmask_next       = hmask_reg;
        pend_valid_next  = pend_valid_reg;
        pend_row_next    = pend_row_reg;
        pend_mask_next   = pend_mask_reg;
        pend_live_next   = pend_live_reg;
        op_next          = op_reg;
        res_status_next  = res_status_reg;
        rd_live_next     = rd_live_reg;
        status_next      = status_reg;
        out_line_next    = out_line_reg;
        out_point_next   = out_point_reg;
        row_bits_next    = row_bits_reg;
        ram_we           = 1'b0;
        ram_waddr        = pend_row_reg;
        ram_wdata        = (pend_live_reg ? ram_rdata : '0) | pend_mask_reg;
        ram_re           = 1'b0;
        ram_raddr        = draw_y_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                opbd_pkg::CFG_WIDTH:  width_next  = cfg_data;
                opbd_pkg::CFG_HEIGHT: height_next = cfg_data;
                default:              width_next  = width_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            opbd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = op;
                    res_status_next = opbd_pkg::STATUS_OK;
                    unique case (op)
                        opbd_pkg::OP_START:
                        begin
                            if (error_seen_reg)
                            begin
                                res_status_next = opbd_pkg::STATUS_IGNORED;
                            end
                            else
                            begin
                                line_count_next  = line_count_reg + 16'd1;
                                point_count_next = 16'd1;
                                if (pt_in)
                                begin
                                    cursor_x_next = px;
                                    cursor_y_next = py;
                                end
                                else
                                begin
                                    res_status_next = opbd_pkg::STATUS_BOUNDS;
                                    error_seen_next = 1'b1;
                                    err_line_next   = line_count_reg + 16'd1;
                                    err_point_next  = 16'd1;
                                end
                            end
                        end
                        opbd_pkg::OP_NEXT:
                        begin
                            if (error_seen_reg)
                            begin
                                res_status_next = opbd_pkg::STATUS_IGNORED;
                            end
                            else
                            begin
                                point_count_next = point_count_reg + 16'd1;
                                if (!pt_in || !cur_in || bad_dir)
                                begin
                                    res_status_next = (!pt_in || !cur_in)
                                        ? opbd_pkg::STATUS_BOUNDS : opbd_pkg::STATUS_DIR;
                                    error_seen_next = 1'b1;
                                    err_line_next   = line_count_reg;
                                    err_point_next  = point_count_reg + 16'd1;
                                end
                                else
                                begin
                                    // The walker keeps its own position, so the
                                    // cursor can move to the end point now.
                                    cursor_x_next   = px;
                                    cursor_y_next   = py;
                                    draw_x_next     = cursor_x_reg;
                                    draw_y_next     = cursor_y_reg;
                                    horiz_next      = (dy == '0);
                                    hmask_next      = range_mask;
                                    draw_left_next  = (dy == '0) ? (RA+1)'(1)
                                                                 : (RA+1)'(ay) + (RA+1)'(1);
                                    x_inc_next      = (dx != '0) && !dx[CA];
                                    x_dec_next      = dx[CA];
                                    y_inc_next      = (dy != '0) && !dy[CA];
                                    y_dec_next      = dy[CA];
                                    pend_valid_next = 1'b0;
                                end
                            end
                        end
                        opbd_pkg::OP_READ:
                        begin
                            // Rows at or beyond the physical height read as zero.
                            ram_re       = 1'b1;
                            ram_raddr    = py;
                            rd_live_next = (y < 7'(H)) && row_valid_reg[py];
                        end
                        opbd_pkg::OP_CLEAR:
                        begin
                            row_valid_next   = '0;
                            cursor_x_next    = '0;
                            cursor_y_next    = '0;
                            line_count_next  = '0;
                            point_count_next = '0;
                            error_seen_next  = 1'b0;
                            err_line_next    = '0;
                            err_point_next   = '0;
                        end
                        default:
                        begin
                            res_status_next = opbd_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            opbd_pkg::S_DRAW:
            begin
                // Write back the row read last cycle.
                if (pend_valid_reg)
                begin
                    ram_we                       = 1'b1;
                    row_valid_next[pend_row_reg] = 1'b1;
                end
                // Read the next row; every row of a segment is distinct, so the
                // overlapping write never targets the row being read.
                if (draw_left_reg != '0)
                begin
                    ram_re          = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_row_next   = draw_y_reg;
                    pend_live_next  = row_valid_reg[draw_y_reg];
                    pend_mask_next  = horiz_reg ? hmask_reg : ({{(W-1){1'b0}}, 1'b1} << draw_x_reg);
                    draw_left_next  = draw_left_reg - (RA+1)'(1);
                    if (x_inc_reg)
                    begin
                        draw_x_next = draw_x_reg + CA'(1);
                    end
                    else if (x_dec_reg)
                    begin
                        draw_x_next = draw_x_reg - CA'(1);
                    end
                    if (y_inc_reg)
                    begin
                        draw_y_next = draw_y_reg + RA'(1);
                    end
                    else if (y_dec_reg)
                    begin
                        draw_y_next = draw_y_reg - RA'(1);
                    end
                end
                else
                begin
                    pend_valid_next = 1'b0;
                end
            end
            opbd_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    out_line_next  = err_line_reg;
                    out_point_next = err_point_reg;
                    // The RAM read data holds while no read is issued.
                    row_bits_next  = (op_reg == opbd_pkg::OP_READ && rd_live_reg)
                                     ? ram_rdata : '0;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= opbd_pkg::S_IDLE;
            width_reg       <= 7'(W);
            height_reg      <= 7'(H);
            row_valid_reg   <= '0;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            line_count_reg  <= '0;
            point_count_reg <= '0;
            error_seen_reg  <= 1'b0;
            err_line_reg    <= '0;
            err_point_reg   <= '0;
            out_valid_reg   <= 1'b0;
            draw_left_reg   <= '0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            row_valid_reg   <= row_valid_next;
            cursor_x_reg    <= cursor_x_next;
            cursor_y_reg    <= cursor_y_next;
            line_count_reg  <= line_count_next;
            point_count_reg <= point_count_next;
            error_seen_reg  <= error_seen_next;
            err_line_reg    <= err_line_next;
            err_point_reg   <= err_point_next;
            out_valid_reg   <= out_valid_next;
            draw_left_reg   <= draw_left_next;
            pend_valid_reg  <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        draw_x_reg     <= draw_x_next;
        draw_y_reg     <= draw_y_next;
        x_inc_reg      <= x_inc_next;
        x_dec_reg      <= x_dec_next;
        y_inc_reg      <= y_inc_next;
        y_dec_reg      <= y_dec_next;
        horiz_reg      <= horiz_next;
        hmask_reg      <= hmask_next;
        pend_row_reg   <= pend_row_next;
        pend_mask_reg  <= pend_mask_next;
        pend_live_reg  <= pend_live_next;
        op_reg         <= op_next;
        res_status_reg <= res_status_next;
        rd_live_reg    <= rd_live_next;
        status_reg     <= status_next;
        out_line_reg   <= out_line_next;
        out_point_reg  <= out_point_next;
        row_bits_reg   <= row_bits_next;
    end

endmodule

[dv/tb_octilinear_polyline_bitmap_draw.sv]
module tb_octilinear_polyline_bitmap_draw;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any transaction on either channel before the run is
    // declared hung. The receiver stalls are short random runs, so this is
    // many times the longest command.
    localparam int STALL_LIMIT   = 4000;
    // Commands in the random part that the block actually acts on.
    localparam int RANDOM_TARGET = 1325;
    // Quiet cycles after the last result, well over the longest draw.
    localparam int TAIL_CYCLES   = 80;

    // One result transaction, as predicted.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] eline;
        logic [15:0] epoint;
        logic [63:0] row;
    } plot_result_t;

    // The scoreboard keeps its own copy of the bitmap, the cursor, the
    // polyline and point counters and the sticky error. Each accepted
    // command is plotted here and its result queued; each result that
    // leaves the block is checked against the oldest queued one.
    class plot_scoreboard;
        logic [6:0]   area_w;
        logic [6:0]   area_h;
        logic [63:0]  pixels [opbd_pkg::MAX_HEIGHT];
        int           cur_x;
        int           cur_y;
        logic [15:0]  line_no;
        logic [15:0]  point_no;
        logic [15:0]  err_line;
        logic [15:0]  err_point;
        bit           faulted;
        plot_result_t expected_results[$];
        int           mismatches;

        function new();
            area_w     = 7'd64;
            area_h     = 7'd64;
            mismatches = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (pixels[i]) pixels[i] = '0;
            cur_x     = 0;
            cur_y     = 0;
            line_no   = '0;
            point_no  = '0;
            err_line  = '0;
            err_point = '0;
            faulted   = 1'b0;
        endfunction

        function bit fits(int px, int py);
            return px < int'(area_w) && px < opbd_pkg::MAX_WIDTH &&
                   py < int'(area_h) && py < opbd_pkg::MAX_HEIGHT;
        endfunction

        task report(string what);
            mismatches++;
            $display("%0t ns: %s", $time, what);
        endtask

        function void note_command(logic [1:0] cmd, logic [6:0] px, logic [6:0] py);
            plot_result_t r;
            int dx;
            int dy;
            int sx;
            int sy;
            int steps;
            r        = '0;
            r.status = opbd_pkg::STATUS_OK;
            if (cmd == opbd_pkg::OP_START || cmd == opbd_pkg::OP_NEXT) begin
                if (faulted) begin
                    r.status = opbd_pkg::STATUS_IGNORED;
                end else if (cmd == opbd_pkg::OP_START) begin
                    line_no++;
                    point_no = 16'd1;
                    if (fits(px, py)) begin
                        cur_x = px;
                        cur_y = py;
                    end else begin
                        r.status = opbd_pkg::STATUS_BOUNDS;
                    end
                end else begin
                    point_no++;
                    // The cursor is checked too: a shrunk area can leave it outside.
                    if (!fits(px, py) || !fits(cur_x, cur_y)) begin
                        r.status = opbd_pkg::STATUS_BOUNDS;
                    end else begin
                        dx = int'(px) - cur_x;
                        dy = int'(py) - cur_y;
                        if (dx != 0 && dy != 0 && dx * dx != dy * dy) begin
                            r.status = opbd_pkg::STATUS_DIR;
                        end else begin
                            sx    = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
                            sy    = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
                            steps = (dx * sx > dy * sy) ? dx * sx : dy * sy;
                            for (int i = 0; i <= steps; i++)
                                pixels[cur_y + i * sy][cur_x + i * sx] = 1'b1;
                            cur_x = px;
                            cur_y = py;
                        end
                    end
                end
                if (r.status == opbd_pkg::STATUS_BOUNDS || r.status == opbd_pkg::STATUS_DIR)
                begin
                    faulted   = 1'b1;
                    err_line  = line_no;
                    err_point = point_no;
                end
            end else if (cmd == opbd_pkg::OP_READ) begin
                if (py < opbd_pkg::MAX_HEIGHT)
                    r.row = pixels[py];
            end else begin
                wipe();
            end
            r.eline  = err_line;
            r.epoint = err_point;
            expected_results.push_back(r);
        endfunction

        task check_result(logic [1:0] st, logic [15:0] el, logic [15:0] ep,
                          logic [63:0] rb);
            plot_result_t want;
            if (expected_results.size() == 0) begin
                report($sformatf("result with none expected: status %0d row %h", st, rb));
                return;
            end
            want = expected_results.pop_front();
            if (st !== want.status)
                report($sformatf("status %0d, expected %0d", st, want.status));
            if (el !== want.eline)
                report($sformatf("error_line %0d, expected %0d", el, want.eline));
            if (ep !== want.epoint)
                report($sformatf("error_point %0d, expected %0d", ep, want.epoint));
            if (rb !== want.row)
                report($sformatf("row_bits %h, expected %h", rb, want.row));
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [1:0]  op        = opbd_pkg::OP_READ;
    logic [6:0]  x         = '0;
    logic [6:0]  y         = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [15:0] error_line;
    logic [15:0] error_point;
    logic [63:0] row_bits;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = opbd_pkg::CFG_WIDTH;
    logic [6:0]  cfg_data  = '0;

    // When clear, both sides run flat out.
    bit idle_on = 1'b1;
    int stall_cycles = 0;

    plot_scoreboard sb = new();

    octilinear_polyline_bitmap_draw u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .x          (x),
        .y          (y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .error_line (error_line),
        .error_point(error_point),
        .row_bits   (row_bits),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls at random, about 29 percent of the time.
    always @(posedge clk)
    begin
        out_ready <= idle_on ? ($urandom_range(99) >= 29) : 1'b1;
    end

    // Every result transaction is checked at the edge where it is taken.
    // All DUT outputs change in the nonblocking region, so the values seen
    // here are the ones present at the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, error_line, error_point, row_bits);
    end

    // Watchdog: a long run of cycles with no transaction means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("octilinear_polyline_bitmap_draw: mismatch");
            $finish;
        end
    end

    // Offers one command and returns at the edge where it is accepted, with
    // valid still high. A random idle gap may come first. The caller either
    // offers the next command at once or calls settle in the same step.
    task automatic send_cmd(logic [1:0] cmd, logic [6:0] px, logic [6:0] py);
        if (idle_on && $urandom_range(99) < 29) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 29);
        end
        in_valid <= 1'b1;
        op       <= cmd;
        x        <= px;
        y        <= py;
        do @(posedge clk); while (!in_ready);
        sb.note_command(cmd, px, py);
    endtask

    // Stops sending and waits until every predicted result has come back,
    // plus a few cycles so the block is surely idle.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes both area registers on consecutive edges. Only call this when
    // the block is idle.
    task automatic set_area(logic [6:0] w, logic [6:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= opbd_pkg::CFG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= opbd_pkg::CFG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.area_w = w;
        sb.area_h = h;
        @(posedge clk);
    endtask

    // Hand-picked commands: corners, the longest segments, a zero-length
    // segment, reads past the bitmap, each error kind, and the odd cases
    // around the sticky error and the cursor.
    task automatic directed_part();
        send_cmd(opbd_pkg::OP_READ, 7'd0, 7'd0);
        // A point with no start continues from the cursor at the origin.
        send_cmd(opbd_pkg::OP_NEXT, 7'd5, 7'd5);
        send_cmd(opbd_pkg::OP_READ, 7'd0, 7'd3);
        send_cmd(opbd_pkg::OP_START, 7'd63, 7'd63);
        send_cmd(opbd_pkg::OP_NEXT, 7'd0, 7'd0);
        send_cmd(opbd_pkg::OP_NEXT, 7'd0, 7'd63);
        send_cmd(opbd_pkg::OP_NEXT, 7'd63, 7'd63);
        // Zero-length segment: sets just the cursor pixel.
        send_cmd(opbd_pkg::OP_NEXT, 7'd63, 7'd63);
        send_cmd(opbd_pkg::OP_NEXT, 7'd63, 7'd0);
        send_cmd(opbd_pkg::OP_READ, 7'd0, 7'd63);
        send_cmd(opbd_pkg::OP_READ, 7'd0, 7'd127);
        // A segment at a forbidden angle sets the sticky error.
        send_cmd(opbd_pkg::OP_NEXT, 7'd10, 7'd5);
        send_cmd(opbd_pkg::OP_START, 7'd1, 7'd1);
        send_cmd(opbd_pkg::OP_READ, 7'd0, 7'd0);
        send_cmd(opbd_pkg::OP_CLEAR, 7'd0, 7'd0);
        // Error with no start: the polyline number stays zero.
        send_cmd(opbd_pkg::OP_NEXT, 7'd64, 7'd0);
        send_cmd(opbd_pkg::OP_CLEAR, 7'd0, 7'd0);
        settle();
        set_area(7'd10, 7'd8);
        send_cmd(opbd_pkg::OP_START, 7'd9, 7'd7);
        send_cmd(opbd_pkg::OP_NEXT, 7'd2, 7'd0);
        send_cmd(opbd_pkg::OP_START, 7'd9, 7'd7);
        // Shrinking the width strands the cursor outside the area.
        settle();
        set_area(7'd5, 7'd8);
        send_cmd(opbd_pkg::OP_READ, 7'd0, 7'd7);
        send_cmd(opbd_pkg::OP_NEXT, 7'd0, 7'd0);
        send_cmd(opbd_pkg::OP_CLEAR, 7'd0, 7'd0);
        // A zero width puts every point out of bounds.
        settle();
        set_area(7'd0, 7'd127);
        send_cmd(opbd_pkg::OP_START, 7'd0, 7'd0);
        send_cmd(opbd_pkg::OP_CLEAR, 7'd0, 7'd0);
        settle();
        set_area(7'd127, 7'd1);
        send_cmd(opbd_pkg::OP_START, 7'd63, 7'd0);
        send_cmd(opbd_pkg::OP_NEXT, 7'd64, 7'd0);
        send_cmd(opbd_pkg::OP_CLEAR, 7'd0, 7'd0);
    endtask

    // Area sizes for a random phase: mostly legal sizes, with the extremes
    // and the out-of-range values now and then.
    function automatic logic [6:0] pick_extent();
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return 7'd0;
        if (r == 1)
            return 7'd127;
        if (r == 2)
            return 7'($urandom_range(127, 65));
        if (r < 5)
            return 7'd1;
        if (r < 8)
            return 7'd64;
        if (r < 12)
            return 7'($urandom_range(16, 1));
        return 7'($urandom_range(64, 1));
    endfunction

    // One random command. Most are legal next points from the current
    // cursor, so polylines grow long; the rest are starts, reads, clears and
    // noise. Once the sticky error is set, clears come often to reopen the
    // block. counted is false for commands the block will ignore.
    task automatic random_command(output bit counted);
        int pick;
        int we;
        int he;
        int lim;
        int len;
        int sx;
        int sy;
        logic [1:0] cmd;
        logic [6:0] px;
        logic [6:0] py;
        we   = (sb.area_w < 7'd64) ? int'(sb.area_w) : opbd_pkg::MAX_WIDTH;
        he   = (sb.area_h < 7'd64) ? int'(sb.area_h) : opbd_pkg::MAX_HEIGHT;
        pick = $urandom_range(99);
        cmd  = opbd_pkg::OP_READ;
        px   = 7'($urandom_range(127));
        py   = 7'($urandom_range(127));
        if (sb.faulted) begin
            if (pick < 35)
                cmd = opbd_pkg::OP_CLEAR;
            else if (pick < 55)
                cmd = opbd_pkg::OP_READ;
            else
                cmd = 2'($urandom_range(3));
        end else if (pick < 6) begin
            cmd = 2'($urandom_range(1));
        end else if (pick < 9) begin
            cmd = opbd_pkg::OP_CLEAR;
        end else if (pick < 23) begin
            cmd = opbd_pkg::OP_READ;
            if ($urandom_range(3) != 0)
                py = 7'($urandom_range(63));
        end else if (we > 0 && he > 0 &&
                     (pick < 33 || !sb.fits(sb.cur_x, sb.cur_y))) begin
            cmd = opbd_pkg::OP_START;
            px  = 7'($urandom_range(we - 1));
            py  = 7'($urandom_range(he - 1));
        end else if (we > 0 && he > 0) begin
            cmd = opbd_pkg::OP_NEXT;
            do begin
                sx = int'($urandom_range(2)) - 1;
                sy = int'($urandom_range(2)) - 1;
            end while (sx == 0 && sy == 0);
            lim = opbd_pkg::MAX_WIDTH;
            if (sx > 0 && we - 1 - sb.cur_x < lim)
                lim = we - 1 - sb.cur_x;
            if (sx < 0 && sb.cur_x < lim)
                lim = sb.cur_x;
            if (sy > 0 && he - 1 - sb.cur_y < lim)
                lim = he - 1 - sb.cur_y;
            if (sy < 0 && sb.cur_y < lim)
                lim = sb.cur_y;
            // Now and then run all the way to the edge of the area.
            len = ($urandom_range(7) == 0) ? lim : int'($urandom_range(lim));
            px  = 7'(sb.cur_x + len * sx);
            py  = 7'(sb.cur_y + len * sy);
        end
        counted = !(sb.faulted && (cmd == opbd_pkg::OP_START || cmd == opbd_pkg::OP_NEXT));
        send_cmd(cmd, px, py);
    endtask

    // Random phases, each with a fresh area setting written while idle. The
    // third phase runs with no idling on either side. Rarely, the sender
    // also stops mid-phase until every result is back.
    task automatic random_part();
        int done_items;
        int phase;
        int size;
        bit counted;
        done_items = 0;
        phase      = 0;
        while (done_items < RANDOM_TARGET) begin
            settle();
            set_area(pick_extent(), pick_extent());
            idle_on = (phase != 2);
            size    = $urandom_range(140, 60);
            for (int k = 0; k < size && done_items < RANDOM_TARGET; k++) begin
                if ($urandom_range(199) == 0)
                    settle();
                random_command(counted);
                if (counted)
                    done_items++;
            end
            phase++;
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_part();
        random_part();
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("octilinear_polyline_bitmap_draw: match");
        else
            $display("octilinear_polyline_bitmap_draw: mismatch");
        $finish;
    end

endmodule
